// File: rtl/ppis_pkg.sv
package ppis_pkg;

  localparam int ADDR_BITS     = 14;
  localparam int OUT_ADDR_W    = 14;
  localparam int PEN_W         = 4;
  localparam int BYTE_W        = 8;
  localparam int SLOT_W        = 3;
  localparam int COL_W         = 7;
  localparam int ROW_W         = 8;
  localparam int MODE_W        = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int ROW_GROUP_W   = ROW_W - 3;
  localparam int ROW_BASE_W    = ROW_GROUP_W + COL_W;
  localparam int STRIDE_SHIFT  = 11;

  localparam logic [MODE_W-1:0] MODE_WIDE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEDIUM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NARROW = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ALIAS  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_MODE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_LINE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS_LAYOUT = 2'd2;

  localparam logic [MODE_W-1:0] RST_PIXEL_MODE     = MODE_MEDIUM;
  localparam logic [COL_W-1:0]  RST_BYTES_PER_LINE = 7'd80;
  localparam logic              LAYOUT_INTERLEAVED = 1'b0;
  localparam logic              LAYOUT_LINEAR      = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] pixel_mode;
    logic [COL_W-1:0]  bytes_per_line;
    logic              address_layout;
  } cfg_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] address;
    logic [BYTE_W-1:0]     data;
    logic                  end_of_line;
  } result_t;

endpackage

// File: rtl/ppis_core.sv
module ppis_core
  import ppis_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic [PEN_W-1:0] pen,
  input  logic             frame_start,
  input  logic             commit,
  output logic             emit,
  output result_t          result
);

  logic [SLOT_W-1:0]    slot_r,    slot_nxt;
  logic [BYTE_W-1:0]    partial_r, partial_nxt;
  logic [COL_W-1:0]     col_r,     col_nxt;
  logic [ROW_W-1:0]     row_r,     row_nxt;
  logic [ADDR_BITS-1:0] addr_r,    addr_nxt;

  logic [SLOT_W-1:0]     slot_cur;
  logic [BYTE_W-1:0]     partial_cur;
  logic [COL_W-1:0]      col_cur;
  logic [ROW_W-1:0]      row_cur;
  logic [ADDR_BITS-1:0]  addr_cur;
  logic [MODE_W-1:0]     mode;
  logic [SLOT_W-1:0]     slot_last;
  logic [BYTE_W-1:0]     placed;
  logic [BYTE_W-1:0]     packed_byte;
  logic [COL_W-1:0]      last_col;
  logic                  eol;
  logic [ROW_W-1:0]      row_inc;
  logic [ROW_BASE_W-1:0] row_base;
  logic [ADDR_BITS-1:0]  row_start;
  logic [ADDR_BITS-1:0]  addr_inc;

  assign slot_cur    = frame_start ? '0 : slot_r;
  assign partial_cur = frame_start ? '0 : partial_r;
  assign col_cur     = frame_start ? '0 : col_r;
  assign row_cur     = frame_start ? '0 : row_r;
  assign addr_cur    = frame_start ? '0 : addr_r;

  assign mode = (cfg.pixel_mode == MODE_ALIAS) ? MODE_MEDIUM : cfg.pixel_mode;

  always_comb begin
    unique case (mode)
      MODE_WIDE: begin
        slot_last = 3'd1;
        if (slot_cur[0]) begin
          placed = {1'b0, pen[3], 1'b0, pen[2], 1'b0, pen[1], 1'b0, pen[0]};
        end else begin
          placed = {pen[3], 1'b0, pen[2], 1'b0, pen[1], 1'b0, pen[0], 1'b0};
        end
      end
      MODE_MEDIUM: begin
        slot_last = 3'd3;
        placed = (BYTE_W'(pen[0]) << (3'd7 - {1'b0, slot_cur[1:0]}))
               | (BYTE_W'(pen[1]) << (3'd3 - {1'b0, slot_cur[1:0]}));
      end
      default: begin
        slot_last = 3'd7;
        placed = BYTE_W'(pen[0]) << (3'd7 - slot_cur);
      end
    endcase
  end

  assign packed_byte = partial_cur | placed;
  assign emit        = slot_cur >= slot_last;

  assign last_col = cfg.bytes_per_line - 7'd1;
  assign eol      = col_cur == last_col;
  assign row_inc  = row_cur + 8'd1;
  assign row_base = ROW_BASE_W'(row_inc[ROW_W-1:3]) * ROW_BASE_W'(cfg.bytes_per_line);
  assign row_start = ADDR_BITS'(row_base)
                   + (ADDR_BITS'(row_inc[2:0]) << STRIDE_SHIFT);
  assign addr_inc = addr_cur + ADDR_BITS'(1);

  assign result.address     = addr_cur[OUT_ADDR_W-1:0];
  assign result.data        = packed_byte;
  assign result.end_of_line = eol;

  always_comb begin
    slot_nxt    = slot_cur;
    partial_nxt = packed_byte;
    col_nxt     = col_cur;
    row_nxt     = row_cur;
    addr_nxt    = addr_cur;
    if (!emit) begin
      slot_nxt = slot_cur + 3'd1;
    end else begin
      slot_nxt    = '0;
      partial_nxt = '0;
      if (eol) begin
        col_nxt = '0;
        row_nxt = row_inc;
        if (cfg.address_layout == LAYOUT_INTERLEAVED) begin
          addr_nxt = row_start;
        end else begin
          addr_nxt = addr_inc;
        end
      end else begin
        col_nxt  = col_cur + 7'd1;
        addr_nxt = addr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      partial_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      addr_r    <= '0;
    end else if (commit) begin
      slot_r    <= slot_nxt;
      partial_r <= partial_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      addr_r    <= addr_nxt;
    end
  end

endmodule

// File: rtl/pixel_pack_interleaved_screen.sv
// Packs palette pens, one per input word in raster order, into screen bytes of
// 2, 4 or 8 pixels (pixel_mode 0, 1, 2; mode 3 acts as mode 1) and emits each
// finished byte with its screen address, interleaved by scanline groups of
// eight or linear per address_layout. A word with frame_start set restarts the
// position counters. A pen is registered in an input stage and each finished
// byte in an output register; one pen is taken every cycle, and input stalls
// only while a finished byte sits in the output register and out_ready is low.
module pixel_pack_interleaved_screen
  import ppis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PEN_W-1:0]       in_pen,
  input  logic                   in_frame_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_ADDR_W-1:0]  out_address,
  output logic [BYTE_W-1:0]      out_data,
  output logic                   out_end_of_line
);

  cfg_t             cfg_r;
  logic             s1_valid_r;
  logic [PEN_W-1:0] s1_pen_r;
  logic             s1_frame_start_r;
  logic             out_valid_r;
  result_t          out_r;
  logic             emit;
  logic             go;
  result_t          result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode     <= RST_PIXEL_MODE;
      cfg_r.bytes_per_line <= RST_BYTES_PER_LINE;
      cfg_r.address_layout <= LAYOUT_INTERLEAVED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_MODE:     cfg_r.pixel_mode     <= cfg_data[MODE_W-1:0];
        CFG_BYTES_PER_LINE: cfg_r.bytes_per_line <= cfg_data[COL_W-1:0];
        CFG_ADDRESS_LAYOUT: cfg_r.address_layout <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign go       = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pen_r         <= in_pen;
      s1_frame_start_r <= in_frame_start;
    end
  end

  ppis_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .pen         (s1_pen_r),
    .frame_start (s1_frame_start_r),
    .commit      (go),
    .emit        (emit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_address     = out_r.address;
  assign out_data        = out_r.data;
  assign out_end_of_line = out_r.end_of_line;

endmodule

// File: rtl/ppis_checker.sv
module ppis_checker
  import ppis_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [OUT_ADDR_W-1:0] out_address,
  input logic [BYTE_W-1:0]     out_data,
  input logic                  out_end_of_line
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_address) && $stable(out_data) && $stable(out_end_of_line))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held output word");

endmodule

bind pixel_pack_interleaved_screen ppis_checker u_ppis_checker (.*);
